// ===== rtl/acia_pkg.sv =====
// shared types and constants for the async serial controller
// no dependencies
package acia_pkg;

  localparam logic [2:0] OP_CTRL_WR = 3'd0;
  localparam logic [2:0] OP_DATA_WR = 3'd1;
  localparam logic [2:0] OP_STAT_RD = 3'd2;
  localparam logic [2:0] OP_DATA_RD = 3'd3;
  localparam logic [2:0] OP_TX_CLK  = 3'd4;
  localparam logic [2:0] OP_RX_CLK  = 3'd5;
  localparam logic [2:0] OP_INJECT  = 3'd6;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd1;
  localparam logic [2:0] PH_PARITY = 3'd2;
  localparam logic [2:0] PH_STOP   = 3'd3;
  localparam logic [2:0] PH_STOP2  = 3'd4;

  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  localparam int ST_RDRF = 0;
  localparam int ST_TDRE = 1;
  localparam int ST_DCD  = 2;
  localparam int ST_CTS  = 3;
  localparam int ST_FE   = 4;
  localparam int ST_OVRN = 5;
  localparam int ST_PE   = 6;
  localparam int ST_IRQ  = 7;

  typedef struct packed {
    logic [3:0] nbits;
    logic [1:0] par;
    logic       two_stop;
  } fmt_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       rxd;
    logic       cts;
    logic       dcd;
  } item_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       txd;
    logic       rts;
    logic       irq_n;
  } result_t;

  function automatic fmt_t fmt_lookup(input logic [2:0] wf);
    fmt_t f;
    case (wf)
      3'd0: f = '{4'd7, PAR_EVEN, 1'b1};
      3'd1: f = '{4'd7, PAR_ODD, 1'b1};
      3'd2: f = '{4'd7, PAR_EVEN, 1'b0};
      3'd3: f = '{4'd7, PAR_ODD, 1'b0};
      3'd4: f = '{4'd8, PAR_NONE, 1'b1};
      3'd5: f = '{4'd8, PAR_NONE, 1'b0};
      3'd6: f = '{4'd8, PAR_EVEN, 1'b0};
      default: f = '{4'd8, PAR_ODD, 1'b0};
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/acia_core.sv =====
// register state and single-pass update of the serial controller
// depends on acia_pkg
module acia_core
  import acia_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  item_t   it,
  output result_t res
);

  logic [7:0] ctrl_r, ctrl_nxt, st_r, st_nxt, thr_r, thr_nxt, rhr_r, rhr_nxt;
  logic [7:0] tsh_r, tsh_nxt, rsh_r, rsh_nxt;
  logic [3:0] tbl_r, tbl_nxt, rbl_r, rbl_nxt;
  logic       tpa_r, tpa_nxt, rpa_r, rpa_nxt;
  logic [2:0] tph_r, tph_nxt, rph_r, rph_nxt;
  logic [6:0] tdv_r, tdv_nxt, rdv_r, rdv_nxt, ratio_r, ratio_nxt;
  logic [2:0] wf_r, wf_nxt;
  logic inres_r, inres_nxt, stread_r, stread_nxt;
  logic ovr_r, ovr_nxt, brk_r, brk_nxt, txint_r, txint_nxt;
  logic irqf_r, irqf_nxt;
  logic txd_r, txd_nxt, rts_r, rts_nxt, irqn_r, irqn_nxt;

  always_comb begin
    fmt_t       f;
    logic [7:0] rd;
    logic [1:0] mode;
    logic       irq;
    logic       tb;
    logic       upd;
    ctrl_nxt = ctrl_r; st_nxt = st_r; thr_nxt = thr_r; rhr_nxt = rhr_r;
    tsh_nxt = tsh_r; rsh_nxt = rsh_r; tbl_nxt = tbl_r; rbl_nxt = rbl_r;
    tpa_nxt = tpa_r; rpa_nxt = rpa_r; tph_nxt = tph_r; rph_nxt = rph_r;
    tdv_nxt = tdv_r; rdv_nxt = rdv_r; ratio_nxt = ratio_r; wf_nxt = wf_r;
    inres_nxt = inres_r; stread_nxt = stread_r;
    ovr_nxt = ovr_r; brk_nxt = brk_r; txint_nxt = txint_r;
    irqf_nxt = irqf_r; txd_nxt = txd_r; rts_nxt = rts_r; irqn_nxt = irqn_r;
    f = fmt_lookup(wf_r);
    rd = 8'd0;
    mode = it.data[6:5];
    tb = 1'b0;
    irq = 1'b0;
    upd = 1'b0;
    case (it.op)
      OP_CTRL_WR: begin
        if (it.data[1:0] == 2'b11) begin
          inres_nxt = 1'b1;
          st_nxt = {4'b0, it.cts, it.dcd, 2'b10};
          thr_nxt = '0; rhr_nxt = '0; tsh_nxt = '0; rsh_nxt = '0;
          tdv_nxt = '0; rdv_nxt = '0;
          ovr_nxt = 1'b0; stread_nxt = 1'b0; irqf_nxt = 1'b0;
          rph_nxt = PH_START; tph_nxt = PH_START;
          txd_nxt = 1'b1; irqn_nxt = 1'b1;
        end else begin
          inres_nxt = 1'b0;
          case (it.data[1:0])
            2'd0: ratio_nxt = 7'd1;
            2'd1: ratio_nxt = 7'd16;
            default: ratio_nxt = 7'd64;
          endcase
        end
        wf_nxt = it.data[4:2];
        txint_nxt = (mode == 2'd1);
        brk_nxt = (mode == 2'd3);
        rts_nxt = (mode == 2'd2);
        ctrl_nxt = it.data;
        upd = 1'b1;
      end
      OP_DATA_WR: begin
        if (!inres_r) begin
          thr_nxt = it.data;
          st_nxt[ST_TDRE] = 1'b0;
          upd = 1'b1;
        end
      end
      OP_STAT_RD: begin
        stread_nxt = 1'b1;
        rd = st_r;
        if (st_r[ST_CTS]) rd[ST_TDRE] = 1'b0;
      end
      OP_DATA_RD: begin
        st_nxt[ST_RDRF] = 1'b0; st_nxt[ST_IRQ] = 1'b0; st_nxt[ST_PE] = 1'b0;
        if (stread_r) begin
          stread_nxt = 1'b0;
          st_nxt[ST_OVRN] = 1'b0;
          st_nxt[ST_DCD] = it.dcd;
        end
        if (ovr_r) begin
          st_nxt[ST_OVRN] = 1'b1;
          ovr_nxt = 1'b0;
        end
        rd = rhr_r;
        upd = 1'b1;
      end
      OP_TX_CLK: begin
        st_nxt[ST_CTS] = it.cts;
        tdv_nxt = tdv_r + 7'd1;
        if (tdv_nxt >= ratio_r) begin
          tdv_nxt = '0;
          case (tph_r)
            PH_START: begin
              if (brk_r) begin
                txd_nxt = 1'b0;
              end else if (st_r[ST_TDRE]) begin
                txd_nxt = 1'b1;
                upd = 1'b1;
              end else begin
                txd_nxt = 1'b0;
                tbl_nxt = f.nbits;
                tsh_nxt = thr_r;
                tpa_nxt = 1'b0;
                tph_nxt = PH_DATA;
                upd = 1'b1;
              end
            end
            PH_DATA: begin
              tb = tsh_r[0];
              txd_nxt = tb;
              tpa_nxt = tpa_r ^ tb;
              tsh_nxt = {1'b0, tsh_r[7:1]};
              tbl_nxt = tbl_r - 4'd1;
              if (tbl_nxt == 4'd0) tph_nxt = (f.par == PAR_NONE) ? PH_STOP : PH_PARITY;
            end
            PH_PARITY: begin
              txd_nxt = (f.par == PAR_EVEN) ? tpa_r : ~tpa_r;
              tph_nxt = PH_STOP;
            end
            PH_STOP: begin
              txd_nxt = 1'b1;
              if (!f.two_stop) begin
                tph_nxt = PH_START; st_nxt[ST_TDRE] = 1'b1;
              end else begin
                tph_nxt = PH_STOP2;
              end
            end
            PH_STOP2: begin
              txd_nxt = 1'b1; tph_nxt = PH_START; st_nxt[ST_TDRE] = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_RX_CLK: begin
        if (it.dcd) begin
          st_nxt[ST_DCD] = 1'b1;
          upd = 1'b1;
        end else if (st_r[ST_DCD] && !st_r[ST_IRQ]) st_nxt[ST_DCD] = 1'b0;
        rdv_nxt = rdv_r + 7'd1;
        if (rdv_nxt >= ratio_r) begin
          rdv_nxt = '0;
          // second carrier check sees the same pin and irq bit, so it is idempotent
          if (st_nxt[ST_DCD]) begin
            rph_nxt = PH_START;
          end else begin
            case (rph_r)
              PH_START: begin
                if (!it.rxd) begin
                  rsh_nxt = '0; rpa_nxt = 1'b0; rbl_nxt = f.nbits; rph_nxt = PH_DATA;
                end
              end
              PH_DATA: begin
                rsh_nxt = rsh_r | {it.rxd, 7'd0};
                rpa_nxt = rpa_r ^ it.rxd;
                rbl_nxt = rbl_r - 4'd1;
                if (rbl_nxt == 4'd0) begin
                  if (st_r[ST_RDRF]) begin
                    ovr_nxt = 1'b1;
                    upd = 1'b1;
                  end
                  rph_nxt = (f.par == PAR_NONE) ? PH_STOP : PH_PARITY;
                end else begin
                  rsh_nxt = {1'b0, rsh_nxt[7:1]};
                end
              end
              PH_PARITY: begin
                rpa_nxt = rpa_r ^ it.rxd;
                if ((f.par == PAR_EVEN) ? rpa_nxt : ~rpa_nxt) st_nxt[ST_PE] = 1'b1;
                rph_nxt = PH_STOP;
              end
              PH_STOP, PH_STOP2: begin
                if (it.rxd) begin
                  if (rph_r == PH_STOP && f.two_stop) begin
                    rph_nxt = PH_STOP2;
                  end else begin
                    st_nxt[ST_FE] = 1'b0;
                    if (!st_r[ST_RDRF]) begin
                      rhr_nxt = rsh_r; st_nxt[ST_RDRF] = 1'b1;
                      upd = 1'b1;
                    end
                    rph_nxt = PH_START;
                  end
                end else begin
                  st_nxt[ST_FE] = 1'b1; rph_nxt = PH_START;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_INJECT: begin
        rhr_nxt = it.data;
        st_nxt[ST_RDRF] = 1'b1;
        upd = 1'b1;
      end
      default: ;
    endcase
    // irq recompute; only where the item would call it
    if (upd) begin
      irq = (txint_nxt && st_nxt[ST_TDRE] && !st_nxt[ST_CTS]) ||
            (ctrl_nxt[7] && (st_nxt[ST_RDRF] || st_nxt[ST_DCD] || ovr_nxt));
      if (irq != irqf_nxt) begin
        irqf_nxt = irq;
        st_nxt[ST_IRQ] = irq;
        irqn_nxt = ~irq;
      end
    end
    res.rd = rd;
    res.txd = txd_nxt;
    res.rts = rts_nxt;
    res.irq_n = irqn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0; st_r <= 8'h02; thr_r <= '0; rhr_r <= '0;
      tsh_r <= '0; rsh_r <= '0; tbl_r <= '0; rbl_r <= '0;
      tpa_r <= 1'b0; rpa_r <= 1'b0; tph_r <= PH_START; rph_r <= PH_START;
      tdv_r <= '0; rdv_r <= '0; ratio_r <= 7'd1; wf_r <= '0;
      inres_r <= 1'b1; stread_r <= 1'b0; ovr_r <= 1'b0;
      brk_r <= 1'b0; txint_r <= 1'b0; irqf_r <= 1'b0;
      txd_r <= 1'b1; rts_r <= 1'b1; irqn_r <= 1'b1;
    end else if (en) begin
      ctrl_r <= ctrl_nxt; st_r <= st_nxt; thr_r <= thr_nxt; rhr_r <= rhr_nxt;
      tsh_r <= tsh_nxt; rsh_r <= rsh_nxt; tbl_r <= tbl_nxt; rbl_r <= rbl_nxt;
      tpa_r <= tpa_nxt; rpa_r <= rpa_nxt; tph_r <= tph_nxt; rph_r <= rph_nxt;
      tdv_r <= tdv_nxt; rdv_r <= rdv_nxt; ratio_r <= ratio_nxt; wf_r <= wf_nxt;
      inres_r <= inres_nxt; stread_r <= stread_nxt;
      ovr_r <= ovr_nxt; brk_r <= brk_nxt; txint_r <= txint_nxt;
      irqf_r <= irqf_nxt; txd_r <= txd_nxt; rts_r <= rts_nxt; irqn_r <= irqn_nxt;
    end
  end

endmodule

// ===== rtl/acia_async_serial_controller.sv =====
// top level of the async serial controller: input register, core, result register
// result path: the input register holds the item until the core updates and the result register loads
// throughput: one item per cycle while out_ready keeps the result register free
// reset: synchronous active-low rst_n empties both registers and loads the
// power-on register state; depends on acia_pkg and acia_core
module acia_async_serial_controller
  import acia_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_write_byte,
  input  logic       in_rxd_level,
  input  logic       in_cts_level,
  input  logic       in_dcd_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_txd_level,
  output logic       out_rts_level,
  output logic       out_irq_n
);

  item_t   item_r;
  logic    iv_r, ov_r;
  result_t res, res_r;
  logic    adv;

  assign adv      = iv_r && (!ov_r || out_ready);
  assign in_ready = !iv_r || adv;

  acia_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .it   (item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (in_ready) iv_r <= in_valid;
      if (adv) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= '{in_operation, in_write_byte, in_rxd_level, in_cts_level, in_dcd_level};
    end
    if (adv) res_r <= res;
  end

  assign out_valid     = ov_r;
  assign out_read_data = res_r.rd;
  assign out_txd_level = res_r.txd;
  assign out_rts_level = res_r.rts;
  assign out_irq_n     = res_r.irq_n;

endmodule
